@@ hw/rtl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial hash value, control structs, state codes and the
// bitwise functions of the compression round and the message schedule.
// ----------------------------------------------------------------------------
package sha_pkg;

	// Eight hash words; element 0 is word a / H0.
	typedef logic [7:0][31:0] word8_t;

	// Control of one cell of the message schedule chain.
	typedef struct packed {
		logic shift_byte;
		logic shift_word;
	} cell_ctrl_t;

	// Control of the round unit.
	typedef struct packed {
		logic load;
		logic step;
	} round_ctrl_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FINAL = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	// Item kinds.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam int unsigned CELLS = 16;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [2:0] LAST_WORD  = 3'd7;

	// Initial hash value, H7 in the top word down to H0 in the bottom word.
	localparam word8_t HASH_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
		ror = (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		choose = (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		majority = (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

@@ hw/rtl/sha_cell.sv @@
// ----------------------------------------------------------------------------
// SHA-256 schedule cell
// One 32-bit word of the block buffer and message schedule window. Takes a
// byte or a whole word from its right-hand neighbour.
// ----------------------------------------------------------------------------
module sha_cell (
	input  logic               clk,
	input  sha_pkg::cell_ctrl_t ctrl,
	input  logic [31:0]        in_word,
	output logic [31:0]        word_q
);
	import sha_pkg::*;

	// A word shift moves the whole neighbour word in; a byte shift moves
	// the neighbour's top byte in at the bottom.
	always_ff @(posedge clk) begin
		if (ctrl.shift_word) begin
			word_q <= in_word;
		end else if (ctrl.shift_byte) begin
			word_q <= {word_q[23:0], in_word[31:24]};
		end
	end

endmodule

@@ hw/rtl/sha_round.sv @@
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds the working variables a to h and performs one compression round
// per cycle.
// ----------------------------------------------------------------------------
module sha_round (
	input  logic                clk,
	input  sha_pkg::round_ctrl_t ctrl,
	input  sha_pkg::word8_t     hash_in,
	input  logic [31:0]         w,
	input  logic [31:0]         k,
	output sha_pkg::word8_t     vars_q
);
	import sha_pkg::*;

	logic [31:0] t1;
	logic [31:0] t2;

	// Temporaries of one round.
	always_comb begin
		t1 = vars_q[7] + big_sig1(vars_q[4]) + choose(vars_q[4], vars_q[5], vars_q[6])
			+ k + w;
		t2 = big_sig0(vars_q[0]) + majority(vars_q[0], vars_q[1], vars_q[2]);
	end

	// Load from the hash words at block start, otherwise rotate one round on a step.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			vars_q <= hash_in;
		end else if (ctrl.step) begin
			vars_q <= {vars_q[6], vars_q[5], vars_q[4], vars_q[3] + t1,
				vars_q[2], vars_q[1], vars_q[0], t1 + t2};
		end
	end

endmodule

@@ hw/rtl/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Takes message bytes and end-of-message items, pads and compresses each
// 64-byte block, and returns the eight digest words of every message.
// ----------------------------------------------------------------------------
//
// Channel  Handshake          Payload
// in       in_valid/in_stall  kind, data_byte
// out      out_valid/out_stall digest_word, word_index, last
//
// The 64th byte of a block starts the 64 rounds of the single round unit and
// then the hash update. An end item pads one byte per cycle to the end of its
// last block, runs the rounds and the hash update for each of its one or two
// blocks, then offers eight digest words, one per cycle while out_stall is low.
// in_stall is high whenever the sequencer is away from idle.
// Reset is asynchronous and restores the initial hash value and empty counts.
//
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);
	import sha_pkg::*;

	state_t       state_q;
	logic [5:0]   fill_q;
	logic [60:0]  byte_total_q;
	logic [5:0]   rnd_q;
	logic [2:0]   emit_q;
	logic         pad_q;
	logic         first_q;
	logic         tail_q;
	logic         fin_q;
	logic [63:0]  len_q;
	word8_t       hash_q;
	word8_t       vars;

	logic         in_take;
	logic         push;
	logic         len_phase;
	logic [7:0]   pad_byte;
	logic [7:0]   push_byte;
	logic [31:0]  new_w;
	cell_ctrl_t   cell_ctrl;
	round_ctrl_t  round_ctrl;
	logic [31:0]  cell_q  [CELLS];
	logic [31:0]  cell_in [CELLS];

	assign in_stall    = (state_q != ST_IDLE);
	assign in_take     = in_valid && !in_stall;
	assign out_valid   = (state_q == ST_EMIT);
	assign digest_word = hash_q[emit_q];
	assign word_index  = emit_q;
	assign last        = (emit_q == LAST_WORD);

	// Byte fed into the buffer: message data, the end marker, zeros or length.
	assign len_phase = tail_q && !first_q && (fill_q >= LEN_POS);
	assign pad_byte  = first_q ? PAD_MARK : (len_phase ? len_q[63:56] : 8'h00);
	assign push      = (in_take && kind == KIND_BYTE) || (state_q == ST_PAD);
	assign push_byte = (state_q == ST_PAD) ? pad_byte : data_byte;

	// Next schedule word from the window held in the chain.
	assign new_w = small_sig1(cell_q[14]) + cell_q[9] + small_sig0(cell_q[1]) + cell_q[0];

	assign cell_ctrl.shift_byte = push;
	assign cell_ctrl.shift_word = (state_q == ST_ROUND);

	assign round_ctrl.load = push && (fill_q == FILL_LAST);
	assign round_ctrl.step = (state_q == ST_ROUND);

	// Chain of schedule cells; the rightmost cell takes the new byte or word.
	genvar gi;
	generate
		for (gi = 0; gi < CELLS; gi++) begin : g_cell
			if (gi == CELLS - 1) begin : g_end
				assign cell_in[gi] = (state_q == ST_ROUND) ? new_w : {push_byte, 24'h000000};
			end else begin : g_mid
				assign cell_in[gi] = cell_q[gi + 1];
			end
			sha_cell u_cell (
				.clk     (clk),
				.ctrl    (cell_ctrl),
				.in_word (cell_in[gi]),
				.word_q  (cell_q[gi])
			);
		end
	endgenerate

	sha_round u_round (
		.clk     (clk),
		.ctrl    (round_ctrl),
		.hash_in (hash_q),
		.w       (cell_q[0]),
		.k       (ROUND_K[rnd_q]),
		.vars_q  (vars)
	);

	// Message length in bits, shifted out a byte at a time during padding.
	always_ff @(posedge clk) begin
		if (in_take && kind == KIND_END) begin
			len_q <= {byte_total_q, 3'b000};
		end else if (state_q == ST_PAD && len_phase) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	// Sequencer, counts and hash words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			byte_total_q <= '0;
			rnd_q        <= '0;
			emit_q       <= '0;
			pad_q        <= 1'b0;
			first_q      <= 1'b0;
			tail_q       <= 1'b0;
			fin_q        <= 1'b0;
			hash_q       <= HASH_IV;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (kind == KIND_BYTE) begin
							fill_q       <= fill_q + 6'd1;
							byte_total_q <= byte_total_q + 61'd1;
							if (fill_q == FILL_LAST) begin
								state_q <= ST_ROUND;
								rnd_q   <= '0;
							end
						end else begin
							pad_q   <= 1'b1;
							first_q <= 1'b1;
							tail_q  <= 1'b0;
							fin_q   <= 1'b0;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// A wrap in the tail block ends the message; any
					// earlier wrap leaves the length for the next block.
					fill_q  <= fill_q + 6'd1;
					first_q <= 1'b0;
					if (fill_q == FILL_LAST) begin
						if (tail_q) begin
							fin_q <= 1'b1;
						end else begin
							tail_q <= 1'b1;
						end
						state_q <= ST_ROUND;
						rnd_q   <= '0;
					end else if (first_q) begin
						tail_q <= (fill_q < LEN_POS);
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == ROUND_LAST) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					for (int j = 0; j < 8; j++) begin
						hash_q[j] <= hash_q[j] + vars[j];
					end
					if (fin_q) begin
						state_q <= ST_EMIT;
						emit_q  <= '0;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!out_stall) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == LAST_WORD) begin
							hash_q       <= HASH_IV;
							byte_total_q <= '0;
							pad_q        <= 1'b0;
							tail_q       <= 1'b0;
							fin_q        <= 1'b0;
							state_q      <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The buffer is empty whenever digest words are offered.
	a_empty_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_q == 6'd0)
		else $error("digest offered with bytes pending");

	// The round count ends in the hash update.
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == ROUND_LAST) |=> state_q == ST_FINAL)
		else $error("compression did not end in hash update");

	// A compression starts only on a full block.
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_ROUND) |-> fill_q == 6'd0)
		else $error("compression started on a partial block");

	// After the last digest word the next message starts clean.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=>
			(byte_total_q == 61'd0 && hash_q == HASH_IV && state_q == ST_IDLE))
		else $error("hash state not restored after digest");

endmodule

@@ tb/sv/sha256_stream_hasher_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams messages of bytes and end items into the hasher and scores every
// digest word against a behavioural SHA-256 held in the bench. Empty and short
// messages go with no gaps or stalls; padding and block boundary lengths and
// random messages under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;
	import sha_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 200;
	localparam int LEN_OFFSET = 56;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] SHA256_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA256_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	typedef logic [7:0] msg_bytes_t [$];

	// Clock, reset and block ports.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = KIND_BYTE;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last;

	// Hash state mirrored by the bench.
	logic [31:0] model_hash [8];
	logic [7:0]  model_block [64];
	logic [5:0]  model_fill;
	logic [60:0] model_len;

	digest_word_t digest_q [$];
	digest_word_t want;

	int gap_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int messages_sent = 0;
	int words_checked = 0;
	int error_count = 0;
	int cycle_count = 0;

	sha256_stream_hasher u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digest_word(digest_word),
		.word_index (word_index),
		.last       (last)
	);

	always #5 clk = ~clk;

	// Bitwise helpers of the round and the message schedule.
	function automatic logic [31:0] rotr32(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] ep0(input logic [31:0] x);
		return rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22);
	endfunction

	function automatic logic [31:0] ep1(input logic [31:0] x);
		return rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25);
	endfunction

	function automatic logic [31:0] mix0(input logic [31:0] x);
		return rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] mix1(input logic [31:0] x);
		return rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
	endfunction

	// Compresses the buffered block into the running hash.
	function automatic void compress_model_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++) begin
			w[i] = {model_block[4 * i], model_block[4 * i + 1],
				model_block[4 * i + 2], model_block[4 * i + 3]};
		end
		for (int i = 16; i < 64; i++) begin
			w[i] = mix1(w[i - 2]) + w[i - 7] + mix0(w[i - 15]) + w[i - 16];
		end
		a = model_hash[0]; b = model_hash[1]; c = model_hash[2]; d = model_hash[3];
		e = model_hash[4]; f = model_hash[5]; g = model_hash[6]; h = model_hash[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + ep1(e) + ((e & f) ^ (~e & g)) + SHA256_K[i] + w[i];
			t2 = ep0(a) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		model_hash[0] += a; model_hash[1] += b; model_hash[2] += c; model_hash[3] += d;
		model_hash[4] += e; model_hash[5] += f; model_hash[6] += g; model_hash[7] += h;
	endfunction

	function automatic void restart_model_hash();
		for (int i = 0; i < 8; i++) model_hash[i] = SHA256_IV[i];
		model_fill = '0;
		model_len = '0;
	endfunction

	// Absorbs one accepted item; an end item pads, finishes the hash and
	// queues the eight digest words it must produce.
	function automatic void sha_absorb(input logic item_kind, input logic [7:0] item_byte);
		logic [63:0] bit_len;
		int n;
		digest_word_t dw;
		if (item_kind == KIND_BYTE) begin
			model_block[model_fill] = item_byte;
			model_fill = model_fill + 6'd1;
			model_len = model_len + 61'd1;
			if (model_fill == 6'd0) compress_model_block();
		end else begin
			bit_len = {model_len, 3'b000};
			n = int'(model_fill);
			model_block[n] = PAD_BYTE;
			n++;
			// No room left for the length: close this block with zeros first.
			if (n > LEN_OFFSET) begin
				while (n < 64) begin
					model_block[n] = 8'h00;
					n++;
				end
				compress_model_block();
				n = 0;
			end
			while (n < LEN_OFFSET) begin
				model_block[n] = 8'h00;
				n++;
			end
			for (int i = 0; i < 8; i++) model_block[LEN_OFFSET + i] = bit_len[8 * (7 - i) +: 8];
			compress_model_block();
			for (int i = 0; i < 8; i++) begin
				dw.word  = model_hash[i];
				dw.index = 3'(i);
				dw.last  = (i == 7);
				digest_q.insert(digest_q.size(), dw);
			end
			messages_sent++;
			restart_model_hash();
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, exp_val);
		error_count++;
	endtask

	// Sends one item after a random gap and waits for it to be taken.
	// Valid is left high; the next call or the caller lowers it.
	task automatic send_item(input logic item_kind, input logic [7:0] item_byte);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= item_kind;
		data_byte <= item_byte;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sha_absorb(item_kind, item_byte);
		items_sent++;
	endtask

	task automatic send_message(input msg_bytes_t msg);
		foreach (msg[i]) send_item(KIND_BYTE, msg[i]);
		send_item(KIND_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_message(input int len);
		msg_bytes_t msg;
		for (int i = 0; i < len; i++) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
		send_message(msg);
	endtask

	// Holds the sender off until every outstanding digest word has come.
	task automatic drain_digests();
		in_valid <= 1'b0;
		@(posedge clk);
		while (digest_q.size() != 0) @(posedge clk);
	endtask

	// Empty messages, straight after reset and back to back.
	task automatic test_empty_message();
		gap_pct = 0;
		stall_pct = 0;
		send_item(KIND_END, 8'h00);
		send_item(KIND_END, 8'hff);
	endtask

	// Single bytes at the extremes, a classic short string and mixed values.
	task automatic test_short_messages();
		send_message('{8'h00});
		send_message('{8'hff});
		send_message('{8'h61, 8'h62, 8'h63});
		send_message('{8'h80, 8'h01, 8'hfe, 8'h7f, 8'h55, 8'haa});
	endtask

	// Lengths where the padding just fits, spills into an extra block, or the
	// message fills a block exactly; each under a different idling pattern.
	task automatic test_pad_boundaries();
		int lens [4] = '{55, 56, 63, 64};
		int gaps [4] = '{0, 54, 0, 34};
		int stalls [4] = '{0, 0, 54, 34};
		for (int i = 0; i < 4; i++) begin
			gap_pct = gaps[i];
			stall_pct = stalls[i];
			send_random_message(lens[i]);
		end
	endtask

	// Random messages, mostly short with the odd one past a block, in four
	// idling phases; the sender waits for all digests at each phase start.
	task automatic test_random_messages();
		int gaps [4] = '{0, 54, 0, 34};
		int stalls [4] = '{0, 0, 54, 34};
		int sent;
		int len;
		for (int p = 0; p < 4; p++) begin
			gap_pct = gaps[p];
			stall_pct = stalls[p];
			drain_digests();
			sent = 0;
			while (sent < 24) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70)
					: $urandom_range(0, 24);
				send_random_message(len);
				sent += len + 1;
			end
		end
	endtask

	task automatic finish_run();
		in_valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Hashed %0d messages from %0d items; %0d digest words checked.",
			messages_sent, items_sent, words_checked);
		$display("Covered empty and short messages, padding boundaries and random gaps/stalls.");
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	endtask

	// Scores each accepted digest word and draws the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (digest_q.size() == 0) begin
				report_mismatch("digest word with none pending", digest_word, 32'h0);
			end else begin
				want = digest_q.pop_front();
				if (digest_word !== want.word)
					report_mismatch("digest_word", digest_word, want.word);
				if (word_index !== want.index)
					report_mismatch("word_index", 32'(word_index), 32'(want.index));
				if (last !== want.last)
					report_mismatch("last", 32'(last), 32'(want.last));
				words_checked++;
			end
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Guards against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d digest words pending.",
				cycle_count, digest_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		restart_model_hash();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_message();
		test_short_messages();
		test_pad_boundaries();
		test_random_messages();
		finish_run();
	end

endmodule

@@ sim.f @@
hw/rtl/sha_pkg.sv
hw/rtl/sha_cell.sv
hw/rtl/sha_round.sv
hw/rtl/sha256_stream_hasher.sv
tb/sv/sha256_stream_hasher_tb.sv
